FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the literal classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts a property on the rising clock edge, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Asserts that a condition is never true on the rising clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/cilc_pkg.sv
// Shared types and constants of the integer literal classifier.
package cilc_pkg;

  localparam int unsigned ValueBitsDef = 64;
  localparam int unsigned CfgW         = 7;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned BitsW        = 7;
  localparam int unsigned SuffixKeep   = 3;
  localparam int unsigned SuffixLenW   = 3;

  localparam logic [CfgW-1:0] IntWidthRst   = 7'd32;
  localparam logic [CfgW-1:0] LongWidthRst  = 7'd64;
  localparam logic [CfgW-1:0] LLongWidthRst = 7'd64;

  localparam logic [7:0] ChApos = 8'h27;
  localparam logic [7:0] ChDot  = 8'h2E;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpB  = 8'h42;
  localparam logic [7:0] ChUpE  = 8'h45;
  localparam logic [7:0] ChUpF  = 8'h46;
  localparam logic [7:0] ChUpL  = 8'h4C;
  localparam logic [7:0] ChUpP  = 8'h50;
  localparam logic [7:0] ChUpU  = 8'h55;
  localparam logic [7:0] ChUpW  = 8'h57;
  localparam logic [7:0] ChUpX  = 8'h58;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowE = 8'h65;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChLowL = 8'h6C;
  localparam logic [7:0] ChLowP = 8'h70;
  localparam logic [7:0] ChLowU = 8'h75;
  localparam logic [7:0] ChLowW = 8'h77;
  localparam logic [7:0] ChLowX = 8'h78;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NO_DIGITS,
    ST_RANGE,
    ST_BAD_SUFFIX,
    ST_NO_TYPE,
    ST_FLOAT
  } status_e;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_LONG,
    KIND_LLONG,
    KIND_BITINT
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INT_WIDTH,
    CFG_LONG_WIDTH,
    CFG_LLONG_WIDTH
  } cfg_idx_e;

  typedef struct packed {
    logic                    float_seen;
    logic                    digit_seen;
    logic                    overflow_seen;
    radix_e                  radix;
    logic [8*SuffixKeep-1:0] suffix_chars;
    logic [SuffixLenW-1:0]   suffix_len;
  } lit_rec_t;

  typedef struct packed {
    logic [CfgW-1:0] int_w;
    logic [CfgW-1:0] long_w;
    logic [CfgW-1:0] llong_w;
  } cfg_t;

endpackage

FILE: rtl/cilc_front.sv
// Character scanner: radix detection, digit accumulation and suffix capture.
module cilc_front import cilc_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            char_code_i,
  input  logic                  is_last_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output logic [VALUE_BITS-1:0] push_value_o,
  output lit_rec_t              push_rec_o
);

  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_SUFFIX
  } phase_e;

  phase_e                  phase_q, phase_d;
  radix_e                  radix_q, radix_d;
  logic [VALUE_BITS-1:0]   acc_q, acc_d;
  logic                    ovf_q, ovf_d;
  logic                    dig_q, dig_d;
  logic                    flt_q, flt_d;
  logic [8*SuffixKeep-1:0] sfx_q, sfx_d;
  logic [SuffixLenW-1:0]   slen_q, slen_d;

  logic                  accept;
  logic                  body_en;
  logic [3:0]            dval;
  logic                  dvalid;
  logic                  dok;
  logic                  fmark;
  logic [VALUE_BITS+3:0] ext;
  logic [VALUE_BITS+3:0] prod;
  logic                  prod_ovf;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && is_last_i;
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    dval   = 4'd0;
    dvalid = 1'b0;
    if (char_code_i inside {[Ch0:Ch9]}) begin
      dval   = 4'(char_code_i - Ch0);
      dvalid = 1'b1;
    end else if (char_code_i inside {[ChLowA:ChLowF]}) begin
      dval   = 4'(char_code_i - ChLowA + 8'd10);
      dvalid = 1'b1;
    end else if (char_code_i inside {[ChUpA:ChUpF]}) begin
      dval   = 4'(char_code_i - ChUpA + 8'd10);
      dvalid = 1'b1;
    end
    case (radix_q)
      RX_HEX:  dok = dvalid;
      RX_OCT:  dok = dvalid && (dval < 4'd8);
      default: dok = dvalid && (dval < 4'd10);
    endcase
    fmark = (char_code_i == ChDot) || (char_code_i == ChLowP) || (char_code_i == ChUpP) ||
            ((radix_q != RX_HEX) && ((char_code_i == ChLowE) || (char_code_i == ChUpE)));
  end

  always_comb begin
    ext = {4'd0, acc_q};
    case (radix_q)
      RX_HEX:  prod = ext << 4;
      RX_OCT:  prod = ext << 3;
      default: prod = (ext << 3) + (ext << 1);
    endcase
    prod     = prod + {{VALUE_BITS{1'b0}}, dval};
    prod_ovf = |prod[VALUE_BITS+3:VALUE_BITS];
  end

  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    dig_d   = dig_q;
    flt_d   = flt_q;
    sfx_d   = sfx_q;
    slen_d  = slen_q;
    body_en = 1'b0;
    if (!flt_q) begin
      case (phase_q)
        PH_START: begin
          if (char_code_i == ChApos) begin
            phase_d = PH_DIGITS;
          end else if (char_code_i == Ch0) begin
            phase_d = PH_ZERO;
            radix_d = RX_OCT;
            dig_d   = 1'b1;
          end else begin
            phase_d = PH_DIGITS;
            body_en = 1'b1;
          end
        end
        PH_ZERO: begin
          if ((char_code_i == ChLowX) || (char_code_i == ChUpX)) begin
            radix_d = RX_HEX;
            dig_d   = 1'b0;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_DIGITS;
            body_en = (char_code_i != ChApos);
          end
        end
        default: body_en = (char_code_i != ChApos);
      endcase
    end
    if (body_en) begin
      if (fmark) begin
        flt_d = 1'b1;
      end else if ((phase_q != PH_SUFFIX) && dok) begin
        dig_d = 1'b1;
        if (!ovf_q) begin
          if (prod_ovf) begin
            ovf_d = 1'b1;
            acc_d = '0;
          end else begin
            acc_d = prod[VALUE_BITS-1:0];
          end
        end
      end else begin
        phase_d = PH_SUFFIX;
        if (slen_q < SuffixLenW'(SuffixKeep)) begin
          sfx_d[8*slen_q[1:0] +: 8] = char_code_i;
        end
        if (slen_q != '1) begin
          slen_d = slen_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    push_value_o               = acc_d;
    push_rec_o.float_seen      = flt_d;
    push_rec_o.digit_seen      = dig_d;
    push_rec_o.overflow_seen   = ovf_d;
    push_rec_o.radix           = radix_d;
    push_rec_o.suffix_chars    = sfx_d;
    push_rec_o.suffix_len      = slen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      radix_q <= RX_DEC;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      dig_q   <= 1'b0;
      flt_q   <= 1'b0;
      sfx_q   <= '0;
      slen_q  <= '0;
    end else if (accept) begin
      if (is_last_i) begin
        phase_q <= PH_START;
        radix_q <= RX_DEC;
        acc_q   <= '0;
        ovf_q   <= 1'b0;
        dig_q   <= 1'b0;
        flt_q   <= 1'b0;
        sfx_q   <= '0;
        slen_q  <= '0;
      end else begin
        phase_q <= phase_d;
        radix_q <= radix_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        dig_q   <= dig_d;
        flt_q   <= flt_d;
        sfx_q   <= sfx_d;
        slen_q  <= slen_d;
      end
    end
  end

endmodule

FILE: rtl/cilc_queue.sv
// Two-entry queue that carries scanned literals from the scanner to the classifier.
module cilc_queue import cilc_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  logic [VALUE_BITS-1:0] push_value_i,
  input  lit_rec_t              push_rec_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output logic [VALUE_BITS-1:0] pop_value_o,
  output lit_rec_t              pop_rec_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [VALUE_BITS-1:0] value_q [Depth];
  lit_rec_t              rec_q   [Depth];
  logic [PtrW-1:0]       wr_ptr_q;
  logic [PtrW-1:0]       rd_ptr_q;
  logic [CntW-1:0]       count_q;
  logic                  push;
  logic                  pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_value_o  = value_q[rd_ptr_q];
  assign pop_rec_o    = rec_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      value_q[wr_ptr_q] <= push_value_i;
      rec_q[wr_ptr_q]   <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/cilc_classify.sv
// Classifier: suffix decoding, bit length, type selection and result register.
module cilc_classify import cilc_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  logic [VALUE_BITS-1:0] pop_value_i,
  input  lit_rec_t              pop_rec_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] literal_value_o,
  output logic [1:0]            type_kind_o,
  output logic                  is_unsigned_o,
  output logic [BitsW-1:0]      bitint_width_o,
  output logic [2:0]            status_o
);

  localparam int unsigned NumGroups = (VALUE_BITS + 7) / 8;
  localparam int unsigned PadW      = NumGroups * 8;

  typedef enum logic [2:0] {
    SFX_NONE,
    SFX_L,
    SFX_LL,
    SFX_WB,
    SFX_BAD
  } sfx_e;

  function automatic logic is_u(input logic [7:0] c);
    return (c == ChLowU) || (c == ChUpU);
  endfunction

  logic                  advance;
  logic [7:0]            s0, s1, s2, slast, ca, cb;
  logic [SuffixLenW-1:0] n, m;
  logic                  sfx_uns;
  logic                  sfx_skip;
  sfx_e                  sfx_kind;
  status_e               pre_status;
  logic [PadW-1:0]       vpad;
  logic [3:0]            glen [NumGroups];

  logic                  s1_valid_q;
  logic [VALUE_BITS-1:0] s1_value_q;
  status_e               s1_pre_q;
  sfx_e                  s1_sfx_q;
  logic                  s1_uns_q;
  logic                  s1_dec_q;
  logic [3:0]            s1_glen_q [NumGroups];

  logic [BitsW-1:0]      bits;
  logic [BitsW:0]        bits_p1;
  logic [CfgW-1:0]       widths [3];
  int unsigned           first_k;
  logic                  found;
  logic                  sgn_ok;
  logic                  uns_ok;
  status_e               res_status;
  kind_e                 res_kind;
  logic                  res_uns;
  logic [BitsW-1:0]      res_bw;
  logic [VALUE_BITS-1:0] res_value;

  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] value_q;
  kind_e                 kind_q;
  logic                  uns_q;
  logic [BitsW-1:0]      bw_q;
  status_e               status_q;

  assign advance     = !out_valid_q || out_ready_i;
  assign pop_ready_o = advance;

  always_comb begin
    s0 = pop_rec_i.suffix_chars[7:0];
    s1 = pop_rec_i.suffix_chars[15:8];
    s2 = pop_rec_i.suffix_chars[23:16];
    n  = pop_rec_i.suffix_len;
    case (n)
      SuffixLenW'(1): slast = s0;
      SuffixLenW'(2): slast = s1;
      default:        slast = s2;
    endcase
    sfx_uns  = 1'b0;
    sfx_skip = 1'b0;
    m        = n;
    sfx_kind = SFX_BAD;
    if (n <= SuffixLenW'(SuffixKeep)) begin
      if ((n != '0) && is_u(s0)) begin
        sfx_uns  = 1'b1;
        sfx_skip = 1'b1;
        m        = n - 1'b1;
      end else if ((n != '0) && is_u(slast)) begin
        sfx_uns = 1'b1;
        m       = n - 1'b1;
      end
    end
    ca = sfx_skip ? s1 : s0;
    cb = sfx_skip ? s2 : s1;
    if (n <= SuffixLenW'(SuffixKeep)) begin
      case (m)
        SuffixLenW'(0): sfx_kind = SFX_NONE;
        SuffixLenW'(1): sfx_kind = ((ca == ChLowL) || (ca == ChUpL)) ? SFX_L : SFX_BAD;
        SuffixLenW'(2): begin
          if (((ca == ChLowL) && (cb == ChLowL)) || ((ca == ChUpL) && (cb == ChUpL))) begin
            sfx_kind = SFX_LL;
          end else if (((ca == ChLowW) && (cb == ChLowB)) ||
                       ((ca == ChUpW) && (cb == ChUpB))) begin
            sfx_kind = SFX_WB;
          end else begin
            sfx_kind = SFX_BAD;
          end
        end
        default: sfx_kind = SFX_BAD;
      endcase
    end
    if (pop_rec_i.float_seen) begin
      pre_status = ST_FLOAT;
    end else if (!pop_rec_i.digit_seen) begin
      pre_status = ST_NO_DIGITS;
    end else if (pop_rec_i.overflow_seen) begin
      pre_status = ST_RANGE;
    end else if (sfx_kind == SFX_BAD) begin
      pre_status = ST_BAD_SUFFIX;
    end else begin
      pre_status = ST_OK;
    end
  end

  always_comb begin
    vpad = PadW'(pop_value_i);
    for (int g = 0; g < NumGroups; g++) begin
      glen[g] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        if (vpad[8*g + b]) begin
          glen[g] = 4'(b + 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pop_valid_i) begin
      s1_value_q <= pop_value_i;
      s1_pre_q   <= pre_status;
      s1_sfx_q   <= sfx_kind;
      s1_uns_q   <= sfx_uns;
      s1_dec_q   <= (pop_rec_i.radix == RX_DEC);
      s1_glen_q  <= glen;
    end
  end

  always_comb begin
    widths[0] = cfg_i.int_w;
    widths[1] = cfg_i.long_w;
    widths[2] = cfg_i.llong_w;
    bits = BitsW'(1);
    for (int g = 0; g < NumGroups; g++) begin
      if (s1_glen_q[g] != 4'd0) begin
        bits = BitsW'(g * 8) + BitsW'(s1_glen_q[g]);
      end
    end
    bits_p1 = {1'b0, bits} + 1'b1;
    case (s1_sfx_q)
      SFX_L:   first_k = 1;
      SFX_LL:  first_k = 2;
      default: first_k = 0;
    endcase
    sgn_ok     = !s1_uns_q;
    uns_ok     = s1_uns_q || !s1_dec_q;
    found      = 1'b0;
    res_status = s1_pre_q;
    res_kind   = KIND_INT;
    res_uns    = 1'b0;
    res_bw     = '0;
    res_value  = '0;
    if (s1_pre_q == ST_OK) begin
      if (s1_sfx_q == SFX_WB) begin
        res_kind  = KIND_BITINT;
        res_uns   = s1_uns_q;
        res_bw    = bits + BitsW'(!s1_uns_q);
        res_value = s1_value_q;
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (!found && (k >= first_k)) begin
            if (sgn_ok && ({1'b0, widths[k]} >= bits_p1)) begin
              res_kind = kind_e'(2'(k));
              res_uns  = 1'b0;
              found    = 1'b1;
            end else if (uns_ok && (widths[k] >= bits)) begin
              res_kind = kind_e'(2'(k));
              res_uns  = 1'b1;
              found    = 1'b1;
            end
          end
        end
        if (found) begin
          res_value = s1_value_q;
        end else begin
          res_status = ST_NO_TYPE;
          res_kind   = KIND_INT;
          res_uns    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      value_q  <= res_value;
      kind_q   <= res_kind;
      uns_q    <= res_uns;
      bw_q     <= res_bw;
      status_q <= res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign literal_value_o = value_q;
  assign type_kind_o     = kind_q;
  assign is_unsigned_o   = uns_q;
  assign bitint_width_o  = bw_q;
  assign status_o        = status_q;

endmodule

FILE: rtl/c_integer_literal_classifier.sv
// Top level of the C integer literal classifier: configuration registers and wiring.
//
//   Channel   Signals                                  Direction
//   input     in_valid_i/in_ready_o, char_code_i,      in
//             is_last_i
//   output    out_valid_o/out_ready_i, literal_value_o, out
//             type_kind_o, is_unsigned_o,
//             bitint_width_o, status_o
//   config    cfg_we_i, cfg_index_i, cfg_data_i        in
//
// One character is taken per cycle while in_ready_o is high; the scanner registers its state.
// After the transfer of the last character, a result passes through the queue, the suffix
// and bit-length stage and the type selection stage before it leaves the output register.
// Reset is asynchronous and clears the scanner, queue and pipeline valid bits.
// A stall on the output backs up the classifier, then the two-entry queue, and
// only then drops in_ready_o.
module c_integer_literal_classifier import cilc_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_code_i,
  input  logic                  is_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] literal_value_o,
  output logic [1:0]            type_kind_o,
  output logic                  is_unsigned_o,
  output logic [BitsW-1:0]      bitint_width_o,
  output logic [2:0]            status_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgW-1:0]       cfg_data_i
);

  cfg_t                  cfg_q;
  logic                  push_valid;
  logic                  push_ready;
  logic [VALUE_BITS-1:0] push_value;
  lit_rec_t              push_rec;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [VALUE_BITS-1:0] pop_value;
  lit_rec_t              pop_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.int_w   <= IntWidthRst;
      cfg_q.long_w  <= LongWidthRst;
      cfg_q.llong_w <= LLongWidthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_INT_WIDTH:   cfg_q.int_w   <= cfg_data_i;
        CFG_LONG_WIDTH:  cfg_q.long_w  <= cfg_data_i;
        CFG_LLONG_WIDTH: cfg_q.llong_w <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cilc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_value_o(push_value),
    .push_rec_o  (push_rec)
  );

  cilc_queue #(
    .VALUE_BITS(VALUE_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_value_i(push_value),
    .push_rec_i  (push_rec),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_value_o (pop_value),
    .pop_rec_o   (pop_rec)
  );

  cilc_classify #(
    .VALUE_BITS(VALUE_BITS)
  ) u_classify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_value_i    (pop_value),
    .pop_rec_i      (pop_rec),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .literal_value_o(literal_value_o),
    .type_kind_o    (type_kind_o),
    .is_unsigned_o  (is_unsigned_o),
    .bitint_width_o (bitint_width_o),
    .status_o       (status_o)
  );

endmodule

FILE: rtl/cilc_checker.sv
// Port-level checker of the literal classifier and its bind to the top level.
`include "assert_macros.svh"

module cilc_checker import cilc_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [VALUE_BITS-1:0] literal_value_o,
  input logic [1:0]            type_kind_o,
  input logic                  is_unsigned_o,
  input logic [BitsW-1:0]      bitint_width_o,
  input logic [2:0]            status_o
);

  logic out_bitint;
  logic out_payload_nz;

  assign out_bitint     = out_valid_o && (type_kind_o == KIND_BITINT);
  assign out_payload_nz = |{literal_value_o, type_kind_o, is_unsigned_o, bitint_width_o};

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  `ASSERT_CLK(a_err_zero, clk_i, rst_ni, out_valid_o && (status_o != ST_OK) |-> !out_payload_nz)

  `ASSERT_CLK(a_width_kind, clk_i, rst_ni, out_valid_o && !out_bitint |-> (bitint_width_o == '0))

  `ASSERT_CLK(a_bitint_width, clk_i, rst_ni, out_bitint |-> (bitint_width_o != '0))

  `ASSERT_NEVER(a_status_code, clk_i, rst_ni, out_valid_o && (status_o > ST_FLOAT))

endmodule

bind c_integer_literal_classifier cilc_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_cilc_checker (.*);
